// ----- rtl/ucs_pkg.sv -----
// Shared definitions for the uniform cubic spline engine: sizes, Q16.16
// constants, register and opcode codes, sequencer states, saturation helpers.
// No dependencies.
package ucs_pkg;

	localparam int MAX_POINTS = 256;
	localparam int AW         = $clog2(MAX_POINTS);
	localparam int NW         = $clog2(MAX_POINTS + 1);
	localparam int DIV_W      = 48;
	localparam int DIV_CW     = $clog2(DIV_W);

	localparam logic signed [31:0] FX_ONE   = 32'sd65536;
	localparam logic signed [31:0] FX_HALF  = 32'sd32768;
	localparam logic signed [31:0] FX_NHALF = -32'sd32768;
	localparam logic signed [31:0] FX_TWO   = 32'sd131072;
	localparam logic signed [31:0] FX_SIXTH = 32'sd10923;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_EVAL  = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		REG_POINT_COUNT = 3'd0,
		REG_ORIGIN_X    = 3'd1,
		REG_GRID_SPACING = 3'd2,
		REG_INV_SPACING = 3'd3,
		REG_START_SLOPE = 3'd4,
		REG_END_SLOPE   = 3'd5,
		REG_SLOPE_LIMIT = 3'd6
	} reg_index_t;

	typedef enum logic [5:0] {
		ST_IDLE,
		ST_SV_RD0, ST_SV_RD1, ST_SV_Y1, ST_SV_B1, ST_SV_B2,
		ST_SV_P, ST_SV_P2, ST_SV_P3, ST_SV_P4, ST_SV_P5, ST_SV_P6, ST_SV_P7, ST_SV_P8,
		ST_SV_E, ST_SV_E1, ST_SV_E2, ST_SV_E3, ST_SV_E4, ST_SV_E5,
		ST_SV_BS0, ST_SV_BS1, ST_SV_BS2,
		ST_EV_START, ST_EV_OUT, ST_EV_DIVW, ST_EV_KH, ST_EV_AB, ST_EV_A, ST_EV_B,
		ST_EV_AA, ST_EV_BB, ST_EV_T1, ST_EV_T2, ST_EV_T3, ST_EV_T4, ST_EV_CUB,
		ST_EV_HH, ST_EV_HH6, ST_EV_V1, ST_EV_V2, ST_EV_V3,
		ST_EV_S1, ST_EV_S2, ST_EV_S3, ST_EV_S4, ST_EV_S5
	} state_t;

	function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
		input logic signed [31:0] b);
		return sat64(64'(a) + 64'(b));
	endfunction

	function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
		input logic signed [31:0] b);
		return sat64(64'(a) - 64'(b));
	endfunction

endpackage

// ----- rtl/ucs_ram.sv -----
// Generic single-write, single-read memory with registered read data.
// No dependencies.
module ucs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- rtl/uniform_cubic_spline_engine.sv -----
// Uniform-grid cubic spline engine, Q16.16; uses ucs_pkg and three ucs_ram stores.
// Sample write: stored at once while idle, and the engine stays ready. Evaluate: runs
// the 48-step interval divider and twenty passes through the one shared 32x32
// multiplier. A stale table is first solved, dominated by one divide per point.
// Reset (arst_n low) clears the sequencer, the configuration registers and marks the table stale.
module uniform_cubic_spline_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic [7:0]         sample_index,
	input  logic signed [31:0] sample_value,
	input  logic signed [31:0] query_x,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] spline_value,
	output logic signed [31:0] spline_slope,
	output logic               outside_grid
);
	import ucs_pkg::*;

	// 3*x - 1.0, saturated, for the slope weights
	function automatic logic signed [31:0] sat_3m1(input logic signed [31:0] v);
		return sat64(64'(v) + (64'(v) <<< 1) - 64'(FX_ONE));
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [8:0]         pcount_q;
	logic signed [31:0] origin_q;
	logic [30:0]        spacing_q;
	logic [30:0]        inv_q;
	logic signed [31:0] sslope_q;
	logic signed [31:0] eslope_q;
	logic signed [31:0] slimit_q;
	logic               cfg_acc;
	logic               cfg_hit;

	// ------------------------------------------------------------------
	// Sequencer and datapath registers
	// ------------------------------------------------------------------
	state_t             state_q, state_d;
	logic               table_cur_q;
	logic               out_load;
	logic               in_acc;
	logic               wr_ok;

	logic signed [31:0] x_q;
	logic signed [32:0] d_q;
	logic signed [32:0] d_cur;
	logic               outside_q;
	logic [AW-1:0]      k_q;
	logic [AW-1:0]      i_q;
	logic signed [31:0] sa_q, sb_q, a_q, b_q, aa_q, bb_q;
	logic signed [31:0] y0_q, y1_q, c0_q, c1_q;
	logic signed [31:0] t1_q, t2_q, t3_q, cub_q, val_q;
	logic signed [31:0] ya_q, yb_q, yc_q;
	logic signed [31:0] cprev_q, uprev_q, cnext_q, uc_q;
	logic signed [31:0] hu_q, t_q, r_q, e_q;

	// derived configuration
	logic [NW-1:0]      neff, nm1, nm2;
	logic [30:0]        h_eff;
	logic signed [31:0] hs, hin, k3;
	logic               start_nat, end_nat;
	logic signed [31:0] qsel;

	// shared multiplier
	logic               mul_en;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod_q;
	logic signed [31:0] mul_res;

	// shared divider
	logic                   div_start;
	logic signed [DIV_W:0]  div_num;
	logic [31:0]            div_den;
	logic [DIV_W-1:0]       div_mag;
	logic                   dv_busy_q;
	logic [DIV_CW-1:0]      dv_cnt_q;
	logic                   dv_neg_q, dv_zero_q;
	logic [31:0]            dv_den_q, dv_rem_q, dv_rem_nx;
	logic [DIV_W-1:0]       dv_quo_q;
	logic [32:0]            dv_trial;
	logic                   dv_bit;
	logic signed [DIV_W:0]  div_res;
	logic signed [31:0]     div_q32;

	// memories
	logic               y_we, c_we, u_we;
	logic [AW-1:0]      y_wa, c_wa, u_wa, y_ra, c_ra, u_ra;
	logic signed [31:0] y_wd, c_wd, u_wd;
	logic [31:0]        y_rd, c_rd, u_rd;

	// misc combinational values
	logic signed [63:0] xb64, xa64;
	logic signed [31:0] p_cur, den_cur, d2_cur;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_acc    = in_valid & in_ready;
	assign cfg_acc   = cfg_valid & cfg_ready;
	assign wr_ok     = (32'(sample_index) < MAX_POINTS);

	// Effective point count: clamp to 2..MAX_POINTS
	always_comb begin
		if (pcount_q < 9'd2) begin
			neff = NW'(2);
		end else if (32'(pcount_q) > MAX_POINTS) begin
			neff = NW'(MAX_POINTS);
		end else begin
			neff = NW'(pcount_q);
		end
	end
	assign nm1 = neff - NW'(1);
	assign nm2 = neff - NW'(2);

	// A zero spacing behaves as one raw step
	assign h_eff     = (spacing_q == 31'd0) ? 31'd1 : spacing_q;
	assign hs        = $signed({1'b0, h_eff});
	assign hin       = $signed({1'b0, inv_q});
	assign k3        = sat64(64'(hin) + (64'(hin) <<< 1));
	assign start_nat = (sslope_q > slimit_q);
	assign end_nat   = (eslope_q > slimit_q);
	assign qsel      = end_nat ? 32'sd0 : FX_HALF;

	assign d_cur   = $signed({x_q[31], x_q}) - $signed({origin_q[31], origin_q});
	assign xb64    = 64'(d_q) - prod_q;
	assign xa64    = 64'(hs) - xb64;
	assign p_cur   = sat_add(mul_res, FX_TWO);
	assign den_cur = sat_add(mul_res, FX_ONE);
	assign d2_cur  = sat_add(sat_sub(yc_q, sat64(64'(yb_q) <<< 1)), ya_q);

	// ------------------------------------------------------------------
	// Configuration write decode
	// ------------------------------------------------------------------
	always_comb begin
		cfg_hit = 1'b0;
		case (cfg_index)
			REG_POINT_COUNT,
			REG_ORIGIN_X,
			REG_GRID_SPACING,
			REG_INV_SPACING,
			REG_START_SLOPE,
			REG_END_SLOPE,
			REG_SLOPE_LIMIT: cfg_hit = cfg_acc;
			default:         cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q  <= 9'd2;
			origin_q  <= '0;
			spacing_q <= 31'd65536;
			inv_q     <= 31'd65536;
			sslope_q  <= '0;
			eslope_q  <= '0;
			slimit_q  <= '0;
		end else if (cfg_acc) begin
			case (cfg_index)
				REG_POINT_COUNT:  pcount_q  <= cfg_data[8:0];
				REG_ORIGIN_X:     origin_q  <= cfg_data;
				REG_GRID_SPACING: spacing_q <= cfg_data[30:0];
				REG_INV_SPACING:  inv_q     <= cfg_data[30:0];
				REG_START_SLOPE:  sslope_q  <= cfg_data;
				REG_END_SLOPE:    eslope_q  <= cfg_data;
				REG_SLOPE_LIMIT:  slimit_q  <= cfg_data;
				default:          ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Shared multiplier: one 32x32 product per cycle, result used the
	// cycle after issue as a saturated Q16.16 value (or raw for grid maths)
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= 64'(mul_a) * 64'(mul_b);
		end
	end
	assign mul_res = sat64(prod_q >>> 16);

	// ------------------------------------------------------------------
	// Shared divider: restoring, one quotient bit per cycle, floor rounding
	// ------------------------------------------------------------------
	assign div_mag   = div_num[DIV_W] ? DIV_W'(-div_num) : DIV_W'(div_num);
	assign dv_trial  = {dv_rem_q, dv_quo_q[DIV_W-1]};
	assign dv_bit    = (dv_trial >= {1'b0, dv_den_q});
	assign dv_rem_nx = dv_bit ? 32'(dv_trial - {1'b0, dv_den_q}) : dv_trial[31:0];

	always_comb begin
		if (dv_zero_q) begin
			div_res = '0;
		end else if (dv_neg_q) begin
			div_res = -$signed({1'b0, dv_quo_q} + (DIV_W + 1)'(|dv_rem_q));
		end else begin
			div_res = $signed({1'b0, dv_quo_q});
		end
	end
	assign div_q32 = sat64(64'(div_res));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_busy_q <= 1'b0;
			dv_cnt_q  <= '0;
		end else if (div_start) begin
			dv_busy_q <= 1'b1;
			dv_cnt_q  <= '0;
		end else if (dv_busy_q) begin
			dv_cnt_q <= dv_cnt_q + DIV_CW'(1);
			if (dv_cnt_q == DIV_CW'(DIV_W - 1)) begin
				dv_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			dv_neg_q  <= div_num[DIV_W];
			dv_zero_q <= (div_den == 32'd0);
			dv_den_q  <= div_den;
			dv_quo_q  <= div_mag;
			dv_rem_q  <= '0;
		end else if (dv_busy_q) begin
			dv_rem_q <= dv_rem_nx;
			dv_quo_q <= {dv_quo_q[DIV_W-2:0], dv_bit};
		end
	end

	// ------------------------------------------------------------------
	// Stores: samples, second derivatives, sweep scratch
	// ------------------------------------------------------------------
	ucs_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_y_ram (
		.clk(clk), .wr_en(y_we), .wr_addr(y_wa), .wr_data(y_wd),
		.rd_addr(y_ra), .rd_data(y_rd)
	);

	ucs_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_c_ram (
		.clk(clk), .wr_en(c_we), .wr_addr(c_wa), .wr_data(c_wd),
		.rd_addr(c_ra), .rd_data(c_rd)
	);

	ucs_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_u_ram (
		.clk(clk), .wr_en(u_we), .wr_addr(u_wa), .wr_data(u_wd),
		.rd_addr(u_ra), .rd_data(u_rd)
	);

	// ------------------------------------------------------------------
	// Sequencer: next state, multiplier/divider issue, memory control
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mul_en    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		y_we      = 1'b0;
		y_wa      = AW'(sample_index);
		y_wd      = sample_value;
		y_ra      = '0;
		c_we      = 1'b0;
		c_wa      = i_q;
		c_wd      = mul_res;
		c_ra      = '0;
		u_we      = 1'b0;
		u_wa      = i_q;
		u_wd      = mul_res;
		u_ra      = i_q;
		out_load  = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (opcode == OP_WRITE) begin
						// store the sample straight away; no result follows
						y_we = wr_ok;
					end else begin
						state_d = table_cur_q ? ST_EV_START : ST_SV_RD0;
					end
				end
			end

			// ---- solve: start boundary ----
			ST_SV_RD0: begin
				y_ra    = '0;
				state_d = ST_SV_RD1;
			end
			ST_SV_RD1: begin
				y_ra    = AW'(1);
				state_d = ST_SV_Y1;
			end
			ST_SV_Y1: begin
				mul_en  = 1'b1;
				mul_a   = hin;
				mul_b   = sat_sub(y_rd, ya_q);
				state_d = ST_SV_B1;
			end
			ST_SV_B1: begin
				mul_en  = 1'b1;
				mul_a   = k3;
				mul_b   = sat_sub(mul_res, sslope_q);
				state_d = ST_SV_B2;
			end
			ST_SV_B2: begin
				c_we    = 1'b1;
				c_wa    = '0;
				c_wd    = start_nat ? 32'sd0 : FX_NHALF;
				u_we    = 1'b1;
				u_wa    = '0;
				u_wd    = start_nat ? 32'sd0 : mul_res;
				state_d = (neff > NW'(2)) ? ST_SV_P : ST_SV_E;
			end

			// ---- solve: forward sweep over interior points ----
			ST_SV_P: begin
				y_ra    = i_q + AW'(1);
				mul_en  = 1'b1;
				mul_a   = FX_HALF;
				mul_b   = cprev_q;
				state_d = ST_SV_P2;
			end
			ST_SV_P2: begin
				div_start = 1'b1;
				div_num   = (DIV_W + 1)'(FX_ONE) <<< 16;
				div_den   = (p_cur > 32'sd0) ? p_cur : 32'd0;
				mul_en    = 1'b1;
				mul_a     = FX_HALF;
				mul_b     = uprev_q;
				state_d   = ST_SV_P3;
			end
			ST_SV_P3: begin
				mul_en  = 1'b1;
				mul_a   = hin;
				mul_b   = d2_cur;
				state_d = ST_SV_P4;
			end
			ST_SV_P4: begin
				mul_en  = 1'b1;
				mul_a   = k3;
				mul_b   = mul_res;
				state_d = ST_SV_P5;
			end
			ST_SV_P5: begin
				state_d = ST_SV_P6;
			end
			ST_SV_P6: begin
				if (!dv_busy_q) begin
					mul_en  = 1'b1;
					mul_a   = FX_NHALF;
					mul_b   = div_q32;
					state_d = ST_SV_P7;
				end
			end
			ST_SV_P7: begin
				c_we    = 1'b1;
				mul_en  = 1'b1;
				mul_a   = r_q;
				mul_b   = t_q;
				state_d = ST_SV_P8;
			end
			ST_SV_P8: begin
				u_we    = 1'b1;
				state_d = ((NW'(i_q) + NW'(1)) < nm1) ? ST_SV_P : ST_SV_E;
			end

			// ---- solve: end boundary ----
			ST_SV_E: begin
				mul_en  = 1'b1;
				mul_a   = hin;
				mul_b   = sat_sub(yb_q, ya_q);
				state_d = ST_SV_E1;
			end
			ST_SV_E1: begin
				mul_en  = 1'b1;
				mul_a   = k3;
				mul_b   = sat_sub(eslope_q, mul_res);
				state_d = ST_SV_E2;
			end
			ST_SV_E2: begin
				mul_en  = 1'b1;
				mul_a   = qsel;
				mul_b   = uprev_q;
				state_d = ST_SV_E3;
			end
			ST_SV_E3: begin
				mul_en  = 1'b1;
				mul_a   = qsel;
				mul_b   = cprev_q;
				state_d = ST_SV_E4;
			end
			ST_SV_E4: begin
				div_start = 1'b1;
				div_num   = (DIV_W + 1)'(t_q) <<< 16;
				div_den   = (den_cur > 32'sd0) ? den_cur : 32'd0;
				state_d   = ST_SV_E5;
			end
			ST_SV_E5: begin
				if (!dv_busy_q) begin
					c_we    = 1'b1;
					c_wa    = AW'(nm1);
					c_wd    = div_q32;
					state_d = ST_SV_BS0;
				end
			end

			// ---- solve: back substitution ----
			ST_SV_BS0: begin
				c_ra    = i_q;
				u_ra    = i_q;
				state_d = ST_SV_BS1;
			end
			ST_SV_BS1: begin
				mul_en  = 1'b1;
				mul_a   = c_rd;
				mul_b   = cnext_q;
				state_d = ST_SV_BS2;
			end
			ST_SV_BS2: begin
				c_we    = 1'b1;
				c_wd    = sat_add(mul_res, uc_q);
				state_d = (i_q == '0) ? ST_EV_START : ST_SV_BS0;
			end

			// ---- evaluate: locate interval ----
			ST_EV_START: begin
				mul_en    = 1'b1;
				mul_a     = 32'(nm1);
				mul_b     = hs;
				div_start = 1'b1;
				div_num   = (DIV_W + 1)'(d_cur);
				div_den   = 32'(h_eff);
				state_d   = ST_EV_OUT;
			end
			ST_EV_OUT: begin
				state_d = ST_EV_DIVW;
			end
			ST_EV_DIVW: begin
				if (!dv_busy_q) begin
					state_d = ST_EV_KH;
				end
			end
			ST_EV_KH: begin
				y_ra    = k_q;
				c_ra    = k_q;
				mul_en  = 1'b1;
				mul_a   = 32'(k_q);
				mul_b   = hs;
				state_d = ST_EV_AB;
			end
			ST_EV_AB: begin
				y_ra    = k_q + AW'(1);
				c_ra    = k_q + AW'(1);
				state_d = ST_EV_A;
			end

			// ---- evaluate: cubic terms ----
			ST_EV_A: begin
				mul_en  = 1'b1;
				mul_a   = hin;
				mul_b   = sa_q;
				state_d = ST_EV_B;
			end
			ST_EV_B: begin
				mul_en  = 1'b1;
				mul_a   = hin;
				mul_b   = sb_q;
				state_d = ST_EV_AA;
			end
			ST_EV_AA: begin
				mul_en  = 1'b1;
				mul_a   = a_q;
				mul_b   = a_q;
				state_d = ST_EV_BB;
			end
			ST_EV_BB: begin
				mul_en  = 1'b1;
				mul_a   = b_q;
				mul_b   = b_q;
				state_d = ST_EV_T1;
			end
			ST_EV_T1: begin
				mul_en  = 1'b1;
				mul_a   = a_q;
				mul_b   = sat_sub(aa_q, FX_ONE);
				state_d = ST_EV_T2;
			end
			ST_EV_T2: begin
				mul_en  = 1'b1;
				mul_a   = b_q;
				mul_b   = sat_sub(bb_q, FX_ONE);
				state_d = ST_EV_T3;
			end
			ST_EV_T3: begin
				mul_en  = 1'b1;
				mul_a   = t1_q;
				mul_b   = c0_q;
				state_d = ST_EV_T4;
			end
			ST_EV_T4: begin
				mul_en  = 1'b1;
				mul_a   = t2_q;
				mul_b   = c1_q;
				state_d = ST_EV_CUB;
			end
			ST_EV_CUB: begin
				mul_en  = 1'b1;
				mul_a   = hs;
				mul_b   = hs;
				state_d = ST_EV_HH;
			end
			ST_EV_HH: begin
				mul_en  = 1'b1;
				mul_a   = mul_res;
				mul_b   = FX_SIXTH;
				state_d = ST_EV_HH6;
			end
			ST_EV_HH6: begin
				mul_en  = 1'b1;
				mul_a   = cub_q;
				mul_b   = mul_res;
				state_d = ST_EV_V1;
			end
			ST_EV_V1: begin
				mul_en  = 1'b1;
				mul_a   = a_q;
				mul_b   = y0_q;
				state_d = ST_EV_V2;
			end
			ST_EV_V2: begin
				mul_en  = 1'b1;
				mul_a   = b_q;
				mul_b   = y1_q;
				state_d = ST_EV_V3;
			end
			ST_EV_V3: begin
				mul_en  = 1'b1;
				mul_a   = hin;
				mul_b   = sat_sub(y1_q, y0_q);
				state_d = ST_EV_S1;
			end

			// ---- evaluate: slope ----
			ST_EV_S1: begin
				mul_en  = 1'b1;
				mul_a   = sat_3m1(bb_q);
				mul_b   = c1_q;
				state_d = ST_EV_S2;
			end
			ST_EV_S2: begin
				mul_en  = 1'b1;
				mul_a   = sat_3m1(aa_q);
				mul_b   = c0_q;
				state_d = ST_EV_S3;
			end
			ST_EV_S3: begin
				mul_en  = 1'b1;
				mul_a   = hs;
				mul_b   = FX_SIXTH;
				state_d = ST_EV_S4;
			end
			ST_EV_S4: begin
				mul_en  = 1'b1;
				mul_a   = mul_res;
				mul_b   = t3_q;
				state_d = ST_EV_S5;
			end
			ST_EV_S5: begin
				// hold here while an earlier result still waits to be taken
				if (!out_valid || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					x_q <= query_x;
				end
			end
			ST_SV_RD1: ya_q <= y_rd;
			ST_SV_Y1:  yb_q <= y_rd;
			ST_SV_B2: begin
				cprev_q <= start_nat ? 32'sd0 : FX_NHALF;
				uprev_q <= start_nat ? 32'sd0 : mul_res;
				i_q     <= AW'(1);
			end
			ST_SV_P2: yc_q <= y_rd;
			ST_SV_P3: hu_q <= mul_res;
			ST_SV_P5: t_q  <= sat_sub(mul_res, hu_q);
			ST_SV_P6: r_q  <= div_q32;
			ST_SV_P7: cprev_q <= mul_res;
			ST_SV_P8: begin
				uprev_q <= mul_res;
				ya_q    <= yb_q;
				yb_q    <= yc_q;
				i_q     <= i_q + AW'(1);
			end
			ST_SV_E2: e_q <= end_nat ? 32'sd0 : mul_res;
			ST_SV_E3: t_q <= sat_sub(e_q, mul_res);
			ST_SV_E5: begin
				cnext_q <= div_q32;
				i_q     <= AW'(nm2);
			end
			ST_SV_BS1: uc_q <= u_rd;
			ST_SV_BS2: begin
				cnext_q <= sat_add(mul_res, uc_q);
				i_q     <= i_q - AW'(1);
			end
			ST_EV_START: d_q <= d_cur;
			ST_EV_OUT: outside_q <= (d_q < 0) || (64'(d_q) > prod_q);
			ST_EV_DIVW: begin
				// clamp the interval index to 0..n-2
				if (div_res < 0) begin
					k_q <= '0;
				end else if (div_res > $signed((DIV_W + 1)'(nm2))) begin
					k_q <= AW'(nm2);
				end else begin
					k_q <= AW'(div_res);
				end
			end
			ST_EV_AB: begin
				sa_q <= sat64(xa64);
				sb_q <= sat64(xb64);
				y0_q <= y_rd;
				c0_q <= c_rd;
			end
			ST_EV_A: begin
				y1_q <= y_rd;
				c1_q <= c_rd;
			end
			ST_EV_B:   a_q  <= mul_res;
			ST_EV_AA:  b_q  <= mul_res;
			ST_EV_BB:  aa_q <= mul_res;
			ST_EV_T1:  bb_q <= mul_res;
			ST_EV_T2:  t1_q <= mul_res;
			ST_EV_T3:  t2_q <= mul_res;
			ST_EV_T4:  t3_q <= mul_res;
			ST_EV_CUB: cub_q <= sat_add(t3_q, mul_res);
			ST_EV_V1:  t3_q <= mul_res;
			ST_EV_V2:  t1_q <= mul_res;
			ST_EV_V3:  val_q <= sat_add(sat_add(t1_q, mul_res), t3_q);
			ST_EV_S1:  t1_q <= mul_res;
			ST_EV_S2:  t2_q <= mul_res;
			ST_EV_S3:  t3_q <= sat_sub(t2_q, mul_res);
			default:   ;
		endcase
	end

	// Table freshness: drop on any register or sample write, set after solve
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_cur_q <= 1'b0;
		end else if (cfg_hit || (in_acc && opcode == OP_WRITE && wr_ok)) begin
			table_cur_q <= 1'b0;
		end else if (state_q == ST_SV_BS2 && i_q == '0) begin
			table_cur_q <= 1'b1;
		end
	end

	// Output register: holds a result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			spline_value <= val_q;
			spline_slope <= sat_add(t1_q, mul_res);
			outside_grid <= outside_q;
		end
	end

endmodule

// ----- rtl/ucs_checker.sv -----
// Port-level checks for the uniform cubic spline engine, bound to the top level.
// Uses ucs_pkg for the opcode codes.
module ucs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_valid,
	input logic               cfg_ready,
	input logic [2:0]         cfg_index,
	input logic [31:0]        cfg_data,
	input logic               in_valid,
	input logic               in_ready,
	input logic               opcode,
	input logic [7:0]         sample_index,
	input logic signed [31:0] sample_value,
	input logic signed [31:0] query_x,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] spline_value,
	input logic signed [31:0] spline_slope,
	input logic               outside_grid
);
	import ucs_pkg::*;

	// a waiting result holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(spline_value) &&
			$stable(spline_slope) && $stable(outside_grid))
		else $error("result changed while stalled");

	// an evaluate item keeps both input sides busy
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode == OP_EVAL |=> !in_ready && !cfg_ready)
		else $error("ready while evaluating");

	// a sample write does not stall the input
	a_write_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode == OP_WRITE |=> in_ready)
		else $error("sample write stalled the input");

	// a result only appears from work in progress
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while idle");

endmodule

bind uniform_cubic_spline_engine ucs_checker u_ucs_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for uniform_cubic_spline_engine: fixed-point spline predictor,
// valid/ready item and register channels, random idling on items and results. Depends on ucs_pkg.
module tb_top;
	import ucs_pkg::*;

	typedef struct {
		logic signed [31:0] value;
		logic signed [31:0] slope;
		logic               outside;
	} spline_res_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               opcode = 1'b0;
	logic [7:0]         sample_index = '0;
	logic signed [31:0] sample_value = '0;
	logic signed [31:0] query_x = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] spline_value;
	logic signed [31:0] spline_slope;
	logic               outside_grid;

	// Predictor state: samples, second derivatives, sweep terms and registers.
	longint      y_tab [MAX_POINTS];
	longint      c_tab [MAX_POINTS];
	longint      u_tab [MAX_POINTS];
	bit          table_ok;
	longint      pt_count, org_x, grid_h, inv_h, slope_start, slope_end, slope_lim;
	spline_res_t pending_results[$];
	int          errors = 0;
	bit          no_idle = 1'b0;
	int          hold_req = 0;

	localparam int SETTLE = 100;

	uniform_cubic_spline_engine dut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#60_000_000;
		$display("[uniform_cubic_spline_engine] ERROR");
		$finish;
	end

	// ---------------------------------------------------------------
	// Fixed-point arithmetic of the spline, every step saturated.
	// ---------------------------------------------------------------
	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Floor division; divisor is always positive here.
	function automatic longint fdiv(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0) q = q - 1;
		return q;
	endfunction

	function automatic longint mulq(longint a, longint b);
		return sat32(fdiv(a * b, 65536));
	endfunction

	function automatic longint divq(longint a, longint b);
		if (b <= 0) return 0;
		return sat32(fdiv(a * 65536, b));
	endfunction

	function automatic longint eff_points();
		if (pt_count < 2) return 2;
		if (pt_count > MAX_POINTS) return MAX_POINTS;
		return pt_count;
	endfunction

	// Tridiagonal sweep for the second derivatives, with the boundary choice.
	function automatic void resolve_table();
		longint n, k3, p, r, d2, q, e;
		int     i;
		n  = eff_points();
		k3 = sat32(3 * inv_h);
		if (slope_start > slope_lim) begin
			c_tab[0] = 0;
			u_tab[0] = 0;
		end else begin
			c_tab[0] = FX_NHALF;
			u_tab[0] = mulq(k3, sat32(mulq(inv_h, sat32(y_tab[1] - y_tab[0])) - slope_start));
		end
		for (i = 1; i < n - 1; i++) begin
			p  = sat32(mulq(FX_HALF, c_tab[i-1]) + FX_TWO);
			r  = divq(FX_ONE, p);
			d2 = sat32(sat32(y_tab[i+1] - sat32(2 * y_tab[i])) + y_tab[i-1]);
			c_tab[i] = mulq(FX_NHALF, r);
			u_tab[i] = mulq(r, sat32(mulq(k3, mulq(inv_h, d2)) - mulq(FX_HALF, u_tab[i-1])));
		end
		if (slope_end > slope_lim) begin
			q = 0;
			e = 0;
		end else begin
			q = FX_HALF;
			e = mulq(k3, sat32(slope_end - mulq(inv_h, sat32(y_tab[n-1] - y_tab[n-2]))));
		end
		c_tab[n-1] = divq(sat32(e - mulq(q, u_tab[n-2])), sat32(mulq(q, c_tab[n-2]) + FX_ONE));
		for (i = n - 2; i >= 0; i--)
			c_tab[i] = sat32(mulq(c_tab[i], c_tab[i+1]) + u_tab[i]);
		table_ok = 1'b1;
	endfunction

	function automatic spline_res_t spline_at(longint xq);
		longint      n, h, d, k, x0, a, b, aa, bb, y0, y1, c0, c1, cub, val, s, grad;
		spline_res_t r;
		if (!table_ok) resolve_table();
		n = eff_points();
		h = (grid_h == 0) ? 1 : grid_h;
		d = xq - org_x;
		r.outside = (d < 0 || d > (n - 1) * h);
		k = fdiv(d, h);
		if (k < 0) k = 0;
		if (k > n - 2) k = n - 2;
		x0  = org_x + k * h;
		a   = mulq(inv_h, sat32(x0 + h - xq));
		b   = mulq(inv_h, sat32(xq - x0));
		y0  = y_tab[k];
		y1  = y_tab[k+1];
		c0  = c_tab[k];
		c1  = c_tab[k+1];
		aa  = mulq(a, a);
		bb  = mulq(b, b);
		cub = sat32(mulq(mulq(a, sat32(aa - FX_ONE)), c0) + mulq(mulq(b, sat32(bb - FX_ONE)), c1));
		val = sat32(sat32(mulq(a, y0) + mulq(b, y1)) + mulq(cub, mulq(mulq(h, h), FX_SIXTH)));
		s   = sat32(mulq(sat32(3 * bb - FX_ONE), c1) - mulq(sat32(3 * aa - FX_ONE), c0));
		grad = sat32(mulq(inv_h, sat32(y1 - y0)) + mulq(mulq(h, FX_SIXTH), s));
		r.value = val[31:0];
		r.slope = grad[31:0];
		return r;
	endfunction

	function automatic void apply_register(reg_index_t idx, logic [31:0] d);
		case (idx)
			REG_POINT_COUNT:  pt_count = d[8:0];
			REG_ORIGIN_X:     org_x = longint'($signed(d));
			REG_GRID_SPACING: grid_h = d[30:0];
			REG_INV_SPACING:  inv_h = d[30:0];
			REG_START_SLOPE:  slope_start = longint'($signed(d));
			REG_END_SLOPE:    slope_end = longint'($signed(d));
			REG_SLOPE_LIMIT:  slope_lim = longint'($signed(d));
			default:          return;
		endcase
		table_ok = 1'b0;
	endfunction

	// ---------------------------------------------------------------
	// Channel drivers
	// ---------------------------------------------------------------
	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 13);
	endfunction

	// Offer one item; hold it until accepted, then update the predictor.
	task automatic send_item(opcode_t op, logic [7:0] idx, logic signed [31:0] v,
		logic signed [31:0] x);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		opcode       <= op;
		sample_index <= idx;
		sample_value <= v;
		query_x      <= x;
		in_valid     <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (op == OP_WRITE) begin
			y_tab[idx] = longint'(v);
			table_ok   = 1'b0;
		end else begin
			pending_results.push_back(spline_at(longint'(x)));
		end
		@(negedge clk);
	endtask

	task automatic drop_input();
		in_valid <= 1'b0;
	endtask

	// Pause the sender until every expected item has come back, then settle.
	task automatic drain();
		drop_input();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_register(reg_index_t idx, logic [31:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		apply_register(idx, d);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic evaluate(logic signed [31:0] x);
		send_item(OP_EVAL, $urandom, $urandom, x);
	endtask

	task automatic store_sample(logic [7:0] idx, logic signed [31:0] v);
		send_item(OP_WRITE, idx, v, $urandom);
	endtask

	// Receiver: draw a stall per item, or take up a long hold when asked.
	initial begin
		int n;
		@(negedge clk);
		forever begin
			n = draw_gap();
			if (hold_req > 0) begin
				n = hold_req;
				hold_req = 0;
			end
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			@(negedge clk);
		end
	end

	task automatic report(string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// Compare every accepted result with the oldest prediction.
	always @(posedge clk) begin
		spline_res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report("result with nothing expected");
			end else begin
				e = pending_results.pop_front();
				if (spline_value !== e.value)
					report($sformatf("spline_value %0d, expected %0d", spline_value, e.value));
				if (spline_slope !== e.slope)
					report($sformatf("spline_slope %0d, expected %0d", spline_slope, e.slope));
				if (outside_grid !== e.outside)
					report($sformatf("outside_grid %0b, expected %0b", outside_grid, e.outside));
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic logic signed [31:0] rand_sample();
		case ($urandom_range(0, 3))
			0:       return $urandom;
			1:       return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			default: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
		endcase
	endfunction

	// Query near the grid in use, now and then anywhere at all.
	function automatic logic signed [31:0] rand_query();
		longint h, n, x;
		if ($urandom_range(0, 9) == 0) return $urandom;
		h = (grid_h == 0) ? 1 : grid_h;
		n = eff_points();
		x = org_x + fdiv(longint'($urandom) * (n + 1) * h, 64'sd4294967296) - h / 2;
		return sat32(x);
	endfunction

	function automatic logic [31:0] rand_slope();
		return ($urandom_range(0, 2) == 0) ? $urandom
			: $signed($urandom_range(0, 1 << 21)) - (1 << 20);
	endfunction

	task automatic random_setting();
		int unsigned h;
		if ($urandom_range(0, 4) == 0)
			write_register(REG_POINT_COUNT, $urandom_range(9, 40));
		else
			write_register(REG_POINT_COUNT, $urandom_range(2, 8));
		case ($urandom_range(0, 2))
			0: begin
				write_register(REG_GRID_SPACING, 32'd65536);
				write_register(REG_INV_SPACING, 32'd65536);
			end
			1: begin
				h = $urandom_range(256, 1 << 22);
				write_register(REG_GRID_SPACING, h);
				write_register(REG_INV_SPACING, (64'd1 << 32) / h);
			end
			default: begin
				write_register(REG_GRID_SPACING, $urandom);
				write_register(REG_INV_SPACING, $urandom);
			end
		endcase
		write_register(REG_ORIGIN_X, ($urandom_range(0, 3) == 0) ? $urandom
			: $signed($urandom_range(0, 1 << 22)) - (1 << 21));
		write_register(REG_START_SLOPE, rand_slope());
		write_register(REG_END_SLOPE, rand_slope());
		write_register(REG_SLOPE_LIMIT, rand_slope());
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Fill the whole sample store so no later read sees an unwritten entry.
	task automatic test_fill_store();
		int i;
		for (i = 0; i < MAX_POINTS; i++) store_sample(i[7:0], rand_sample());
		evaluate(32'sd32768);
		drain();
	endtask

	// Field extremes and the edge cases of the grid, on a four-point grid.
	task automatic test_edges();
		write_register(REG_POINT_COUNT, 9'd4);
		write_register(REG_START_SLOPE, 32'h0001_0000);
		write_register(REG_SLOPE_LIMIT, 32'h0002_0000);
		store_sample(8'd0, 32'sh7fffffff);
		store_sample(8'd1, 32'sh80000000);
		store_sample(8'd2, 32'sd0);
		store_sample(8'd3, -32'sd1);
		store_sample(8'd255, 32'sh5555aaaa);
		evaluate(32'sh80000000);
		evaluate(32'sh7fffffff);
		evaluate(32'sd0);
		evaluate(32'sh0003_0000);
		evaluate(32'sh0003_0001);
		evaluate(-32'sd1);
		evaluate(32'sh0001_8000);
		store_sample(8'd1, 32'sd65536);
		store_sample(8'd2, -32'sd65536);
		evaluate(32'sh0002_4000);
		evaluate(32'sh0000_0001);
		drain();
	endtask

	// Register extremes: clipped point counts, zero spacing, both boundary kinds.
	task automatic test_registers();
		write_register(REG_POINT_COUNT, 9'd0);
		evaluate(32'sh0000_c000);
		drain();
		write_register(REG_POINT_COUNT, 9'd1);
		write_register(REG_GRID_SPACING, 32'd0);
		evaluate(32'sd1);
		drain();
		write_register(REG_GRID_SPACING, 32'hffff_ffff);
		write_register(REG_INV_SPACING, 32'd0);
		write_register(REG_ORIGIN_X, 32'h8000_0000);
		evaluate(32'sh7fffffff);
		drain();
		write_register(REG_INV_SPACING, 32'h7fff_ffff);
		write_register(REG_START_SLOPE, 32'h8000_0000);
		write_register(REG_END_SLOPE, 32'h7fff_ffff);
		write_register(REG_SLOPE_LIMIT, 32'h8000_0000);
		write_register(REG_GRID_SPACING, 32'd65536);
		write_register(REG_ORIGIN_X, 32'h7fff_0000);
		evaluate(32'sh7fff_8000);
		drain();
		write_register(REG_POINT_COUNT, 9'd511);
		write_register(REG_INV_SPACING, 32'd65536);
		write_register(REG_ORIGIN_X, 32'd0);
		write_register(REG_SLOPE_LIMIT, 32'h7fff_ffff);
		evaluate(32'sh00ff_0000);
		evaluate(32'sh0080_4000);
		drain();
		write_register(REG_POINT_COUNT, 9'd256);
		write_register(REG_END_SLOPE, 32'h0000_4000);
		evaluate(32'sh00fe_ffff);
		drain();
	endtask

	// Hold off the receiver for a long stretch while evaluations keep coming.
	task automatic test_backpressure();
		int i;
		write_register(REG_POINT_COUNT, 9'd3);
		evaluate(32'sh0000_8000);
		hold_req = 600;
		no_idle  = 1'b1;
		for (i = 0; i < 12; i++) evaluate(rand_query());
		no_idle = 1'b0;
		drain();
	endtask

	// Random phases: mostly sample writes with random content, some evaluations.
	task automatic test_random();
		int phase, i;
		longint n;
		for (phase = 0; phase < 10; phase++) begin
			random_setting();
			n = eff_points();
			no_idle = (phase % 4 == 3);
			for (i = 0; i < 78; i++) begin
				if ($urandom_range(0, 9) < 6)
					store_sample(($urandom_range(0, 5) == 0) ? $urandom
						: $urandom_range(0, n - 1), rand_sample());
				else
					evaluate(rand_query());
			end
			no_idle = 1'b0;
			drain();
		end
	endtask

	initial begin
		y_tab       = '{default: 0};
		c_tab       = '{default: 0};
		u_tab       = '{default: 0};
		table_ok    = 1'b0;
		pt_count    = 2;
		org_x       = 0;
		grid_h      = 65536;
		inv_h       = 65536;
		slope_start = 0;
		slope_end   = 0;
		slope_lim   = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (4) @(negedge clk);

		test_fill_store();
		test_edges();
		test_registers();
		test_backpressure();
		test_random();
		drain();

		if (errors == 0) begin
			$display("[uniform_cubic_spline_engine] OK");
		end else begin
			$display("[uniform_cubic_spline_engine] ERROR");
		end
		$finish;
	end

endmodule
